// ----- src/gld_pkg.sv -----
// shared constants, types and controller/datapath interface structs for the
// grid line central difference block; no dependencies
`default_nettype none

package gld_pkg;

  localparam int DW          = 32;   // sample and position width, signed fixed point
  localparam int FB          = 16;   // fractional bits
  localparam int MIN_LINE    = 3;    // shortest line with a real central difference
  localparam int LC_W        = 2;    // line count, saturates at MIN_LINE
  localparam int CNT_W       = $clog2(DW);
  localparam int IN_TDATA_W  = ((2 * DW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DW + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    OSEL_RES,
    OSEL_PEND,
    OSEL_SHORT
  } osel_t;

  typedef struct packed {
    logic  accept;
    logic  in_end;
    logic  setup;
    logic  check;
    logic  div_step;
    logic  finish;
    logic  store_pend;
    logic  out_load;
    osel_t out_sel;
    logic  out_last;
  } gld_cmd_t;

  typedef struct packed {
    logic pair_ok;
    logic presat;
    logic out_free;
  } gld_stat_t;

endpackage

`default_nettype wire

// ----- src/gld_datapath.sv -----
// datapath: sample history, restoring divider, result and pending registers,
// output word register; depends on gld_pkg
`default_nettype none

module gld_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [gld_pkg::IN_TDATA_W-1:0]   in_tdata,   // position, sample
  input  logic [gld_pkg::IN_TUSER_W-1:0]   in_tuser,   // sample_valid
  input  gld_pkg::gld_cmd_t                cmd,
  output gld_pkg::gld_stat_t               stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gld_pkg::OUT_TDATA_W-1:0]  out_tdata,  // slope
  output logic [gld_pkg::OUT_TUSER_W-1:0]  out_tuser,  // slope_valid, saturated, short_line
  output logic                             out_tlast
);
  import gld_pkg::*;

  localparam int WIDE = DW + FB + 1;

  logic [DW-1:0] in_pos;
  logic [DW-1:0] in_val;
  logic          in_ok;

  logic [DW-1:0] older_pos_r, older_val_r, newer_pos_r, newer_val_r;
  logic          older_ok_r, newer_ok_r;

  logic [DW:0]   dv_r, dp_r;
  logic          pair_ok_r;
  logic          neg_r;
  logic [DW:0]   a_r, b_r;
  logic          presat_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] dsh_r;
  logic [DW-1:0] q_r;

  logic [WIDE-1:0] ext;
  logic [FB:0]     ext_top;
  logic [DW+1:0]   trial;
  logic [DW+1:0]   trial_diff;

  logic [DW-1:0] lim, mag;
  logic          sat;
  logic [DW-1:0] res_slope_nxt;
  logic          res_ok_nxt, res_sat_nxt;

  logic [DW-1:0] res_slope_r, pend_slope_r;
  logic          res_ok_r, res_sat_r, pend_ok_r, pend_sat_r;

  logic [DW-1:0] out_slope_r;
  logic          out_valid_r, out_ok_r, out_sat_r, out_short_r, out_last_r;

  assign in_pos = in_tdata[DW-1:0];
  assign in_val = in_tdata[2*DW-1:DW];
  assign in_ok  = in_tuser[0];

  // numerator scaled by the fraction bits; the part above DW bits must be below
  // the divisor or the quotient overflows
  assign ext     = WIDE'(a_r) << FB;
  assign ext_top = ext[WIDE-1:DW];

  assign trial      = {rem_r, dsh_r[DW-1]};
  assign trial_diff = trial - {1'b0, b_r};

  always_comb begin
    lim = neg_r ? (DW'(1) << (DW - 1)) : ((DW'(1) << (DW - 1)) - DW'(1));
    sat = presat_r | (q_r > lim);
    mag = sat ? lim : q_r;
    if (pair_ok_r) begin
      res_slope_nxt = neg_r ? (~mag + 1'b1) : mag;
      res_ok_nxt    = 1'b1;
      res_sat_nxt   = sat;
    end else begin
      res_slope_nxt = '0;
      res_ok_nxt    = 1'b0;
      res_sat_nxt   = 1'b0;
    end
  end

  assign stat.pair_ok  = pair_ok_r;
  assign stat.presat   = ((DW + 1)'(ext_top) >= b_r);
  assign stat.out_free = ~out_valid_r | out_tready;

  // sample history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_ok_r <= 1'b0;
      newer_ok_r <= 1'b0;
    end else if (cmd.accept) begin
      if (cmd.in_end) begin
        older_ok_r <= 1'b0;
        newer_ok_r <= 1'b0;
      end else begin
        older_ok_r <= newer_ok_r;
        newer_ok_r <= in_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      older_pos_r <= newer_pos_r;
      older_val_r <= newer_val_r;
      newer_pos_r <= in_pos;
      newer_val_r <= in_val;
      dv_r        <= {in_val[DW-1], in_val} - {older_val_r[DW-1], older_val_r};
      dp_r        <= {in_pos[DW-1], in_pos} - {older_pos_r[DW-1], older_pos_r};
      pair_ok_r   <= older_ok_r & in_ok & (older_pos_r != in_pos);
    end
    if (cmd.setup) begin
      neg_r <= dv_r[DW] ^ dp_r[DW];
      a_r   <= dv_r[DW] ? (~dv_r + 1'b1) : dv_r;
      b_r   <= dp_r[DW] ? (~dp_r + 1'b1) : dp_r;
    end
    if (cmd.check) begin
      presat_r <= stat.presat;
      rem_r    <= (DW + 1)'(ext_top);
      dsh_r    <= ext[DW-1:0];
      q_r      <= '0;
    end
    if (cmd.div_step) begin
      dsh_r <= dsh_r << 1;
      if (!trial_diff[DW+1]) begin
        rem_r <= trial_diff[DW:0];
        q_r   <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DW:0];
        q_r   <= {q_r[DW-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      res_slope_r <= res_slope_nxt;
      res_ok_r    <= res_ok_nxt;
      res_sat_r   <= res_sat_nxt;
    end
    if (cmd.store_pend) begin
      pend_slope_r <= res_slope_nxt;
      pend_ok_r    <= res_ok_nxt;
      pend_sat_r   <= res_sat_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      case (cmd.out_sel)
        OSEL_PEND: begin
          out_slope_r <= pend_slope_r;
          out_ok_r    <= pend_ok_r;
          out_sat_r   <= pend_sat_r;
          out_short_r <= 1'b0;
        end
        OSEL_SHORT: begin
          out_slope_r <= '0;
          out_ok_r    <= 1'b0;
          out_sat_r   <= 1'b0;
          out_short_r <= 1'b1;
        end
        default: begin
          out_slope_r <= res_slope_r;
          out_ok_r    <= res_ok_r;
          out_sat_r   <= res_sat_r;
          out_short_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_slope_r);
  assign out_tuser  = {out_short_r, out_sat_r, out_ok_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- src/gld_ctrl.sv -----
// controller: line position tracking, result plan per sample, divider
// sequencing and output word issue; depends on gld_pkg
`default_nettype none

module gld_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tlast,
  output logic               in_tready,
  output gld_pkg::gld_cmd_t  cmd,
  input  gld_pkg::gld_stat_t stat
);
  import gld_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEND,
    ST_SETUP,
    ST_CHECK,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

  state_t            state_r;
  logic [LC_W-1:0]   lc_r;
  logic              pend_full_r;
  logic              plan_div_r;
  logic [1:0]        emit_cnt_r;
  logic              short_r;
  logic              last_final_r;
  logic              set_pend_r;
  logic [CNT_W-1:0]  div_cnt_r;

  logic              accept;
  logic              lc_lt2, lc_eq2;
  logic              p_div, p_last, p_short, p_pend;
  logic [1:0]        p_cnt;
  logic [LC_W-1:0]   lc_nxt;

  function automatic state_t after_pend(input logic div, input logic [1:0] cnt);
    state_t s;
    if (div) s = ST_SETUP;
    else if (cnt != 2'd0) s = ST_EMIT;
    else s = ST_IDLE;
    return s;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  // what this sample produces, decided from its line position
  always_comb begin
    lc_lt2  = lc_r < LC_W'(MIN_LINE - 1);
    lc_eq2  = lc_r == LC_W'(MIN_LINE - 1);
    p_div   = ~lc_lt2;
    p_short = in_tlast & lc_lt2;
    p_last  = in_tlast & ~lc_eq2;
    p_pend  = in_tlast & lc_eq2;
    if (in_tlast) begin
      p_cnt = (lc_r == '0) ? 2'd1 : 2'd2;
    end else if (lc_eq2) begin
      p_cnt = 2'd2;
    end else if (lc_lt2) begin
      p_cnt = 2'd0;
    end else begin
      p_cnt = 2'd1;
    end
    if (in_tlast) begin
      lc_nxt = '0;
    end else if (lc_r == LC_W'(MIN_LINE)) begin
      lc_nxt = lc_r;
    end else begin
      lc_nxt = lc_r + 1'b1;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.out_sel  = OSEL_RES;
    cmd.accept   = accept;
    cmd.in_end   = in_tlast;
    case (state_r)
      ST_PEND: begin
        cmd.out_load = stat.out_free;
        cmd.out_sel  = OSEL_PEND;
        cmd.out_last = 1'b1;
      end
      ST_SETUP: cmd.setup    = 1'b1;
      ST_CHECK: cmd.check    = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FIN: begin
        cmd.finish     = 1'b1;
        cmd.store_pend = set_pend_r;
      end
      ST_EMIT: begin
        cmd.out_load = stat.out_free;
        cmd.out_sel  = short_r ? OSEL_SHORT : OSEL_RES;
        cmd.out_last = last_final_r & (emit_cnt_r == 2'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lc_r         <= '0;
      pend_full_r  <= 1'b0;
      plan_div_r   <= 1'b0;
      emit_cnt_r   <= 2'd0;
      short_r      <= 1'b0;
      last_final_r <= 1'b0;
      set_pend_r   <= 1'b0;
      div_cnt_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            lc_r         <= lc_nxt;
            plan_div_r   <= p_div;
            emit_cnt_r   <= p_cnt;
            short_r      <= p_short;
            last_final_r <= p_last;
            set_pend_r   <= p_pend;
            state_r      <= pend_full_r ? ST_PEND : after_pend(p_div, p_cnt);
          end
        end
        ST_PEND: begin
          if (stat.out_free) begin
            pend_full_r <= 1'b0;
            state_r     <= after_pend(plan_div_r, emit_cnt_r);
          end
        end
        ST_SETUP: begin
          state_r <= stat.pair_ok ? ST_CHECK : ST_FIN;
        end
        ST_CHECK: begin
          div_cnt_r <= '0;
          state_r   <= stat.presat ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == CNT_W'(DW - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (set_pend_r) begin
            pend_full_r <= 1'b1;
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (stat.out_free) begin
            emit_cnt_r <= emit_cnt_r - 1'b1;
            if (emit_cnt_r == 2'd1) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/grid_line_central_difference.sv -----
// top level of the grid line central difference block
// depends on gld_pkg, gld_ctrl and gld_datapath
`default_nettype none

// Samples of one grid line enter in line order, one word each; the line's
// last sample carries in_tlast. Each interior sample gets the slope
// (v[i+1]-v[i-1])/(p[i+1]-p[i-1]) in signed Q16.16, clamped to 32 bits with
// a saturated flag; the end samples repeat their neighbor's slope. Results lag
// one sample: the third word of a line releases two result words, the last
// word releases the last two, and for a three-sample line the third result
// leaves ahead of the next line's results. Lines of one or two samples return
// short_line words with zero slope. A word that needs a division goes through
// capture, operand setup, range check, 32 steps of a radix-2 restoring divider
// and the truncate/clamp step, then issues its result words in turn; an invalid
// pair or a position tie skips the check and the divider, and an over-range
// quotient skips the divider. Words without a division go from capture straight
// to issue, a held-over third result is issued before the new word is handled,
// and a stalled output register holds the controller until it frees. A finished
// word waits in the output register while the next input is taken.
module grid_line_central_difference (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gld_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] position, [63:32] sample
  input  logic [gld_pkg::IN_TUSER_W-1:0]   in_tuser,   // [0] sample_valid
  input  logic                             in_tlast,   // line_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gld_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [31:0] slope
  output logic [gld_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] slope_valid, [1] saturated,
                                                       // [2] short_line
  output logic                             out_tlast   // line_last
);
  import gld_pkg::*;

  gld_cmd_t  cmd;
  gld_stat_t stat;

  gld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  gld_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- src/gld_checker.sv -----
// port-level checks on the result channel of grid_line_central_difference
// bound to the top level; depends on gld_pkg
`default_nettype none

module gld_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gld_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [gld_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input logic                             out_tlast
);
  import gld_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("invalid slope not zero or flagged saturated");

  a_short_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[0])
    else $error("short line word marked valid");

  a_sat_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("saturated flag on invalid slope");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

endmodule

bind grid_line_central_difference gld_checker u_gld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- bench/slope_stream_checker.sv -----
`timescale 1ns / 1ps
// stream checker for grid_line_central_difference: predicts the slope words of
// every accepted sample word and compares them with the result stream
// depends on gld_pkg
module slope_stream_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [gld_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] position, [63:32] sample
  input  logic [gld_pkg::IN_TUSER_W-1:0]  in_tuser,   // [0] sample_valid
  input  logic                            in_tlast,   // line_end
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [gld_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] slope
  input  logic [gld_pkg::OUT_TUSER_W-1:0] out_tuser,  // [0] slope_valid, [1] saturated,
                                                      // [2] short_line
  input  logic                            out_tlast,  // line_last
  output int                              words_owed,
  output int                              mismatches
);
  import gld_pkg::*;

  typedef struct packed {
    logic [DW-1:0] slope;
    logic          slope_valid;
    logic          saturated;
    logic          short_line;
    logic          line_last;
  } slope_word_t;

  // the two samples behind the current one
  logic signed [DW-1:0] prev2_pos, prev2_val, prev1_pos, prev1_val;
  logic                 prev2_ok, prev1_ok;
  logic [LC_W-1:0]      line_len;
  slope_word_t          slopes_due[$];
  int                   fail_total = 0;
  int                   owed_now = 0;

  assign mismatches = fail_total;
  assign words_owed = owed_now;

  function automatic slope_word_t central_slope(
    input logic signed [DW-1:0] p0, input logic signed [DW-1:0] v0, input logic ok0,
    input logic signed [DW-1:0] p2, input logic signed [DW-1:0] v2, input logic ok2
  );
    slope_word_t        w;
    logic signed [DW:0] dv, dp;
    logic [DW:0]        av, ap;
    logic [63:0]        quo, bound;
    logic               neg;
    w = '0;
    if (!ok0 || !ok2 || p0 == p2) return w;
    dv = $signed({v2[DW-1], v2}) - $signed({v0[DW-1], v0});
    dp = $signed({p2[DW-1], p2}) - $signed({p0[DW-1], p0});
    neg = dv[DW] ^ dp[DW];
    av = dv[DW] ? -dv : dv;
    ap = dp[DW] ? -dp : dp;
    // exact quotient of the magnitudes, truncated toward zero
    quo = (64'(av) << FB) / 64'(ap);
    bound = neg ? (64'(1) << (DW - 1)) : (64'(1) << (DW - 1)) - 64'(1);
    if (quo > bound) begin
      quo = bound;
      w.saturated = 1'b1;
    end
    w.slope = neg ? DW'(-quo) : DW'(quo);
    w.slope_valid = 1'b1;
    return w;
  endfunction

  task automatic predict_slopes(input logic signed [DW-1:0] pos, input logic signed [DW-1:0] val,
                                input logic ok, input logic eol);
    slope_word_t r;
    if (eol) begin
      if (line_len < LC_W'(MIN_LINE - 1)) begin
        r = '0;
        r.short_line = 1'b1;
        if (line_len == LC_W'(1)) slopes_due.push_back(r);
        r.line_last = 1'b1;
        slopes_due.push_back(r);
      end else begin
        r = central_slope(prev2_pos, prev2_val, prev2_ok, pos, val, ok);
        slopes_due.push_back(r);
        // a three-sample line leaves its last word behind, still next in order
        if (line_len == LC_W'(MIN_LINE - 1)) slopes_due.push_back(r);
        r.line_last = 1'b1;
        slopes_due.push_back(r);
      end
      prev2_pos = '0;
      prev2_val = '0;
      prev2_ok  = 1'b0;
      prev1_pos = '0;
      prev1_val = '0;
      prev1_ok  = 1'b0;
      line_len  = '0;
    end else begin
      if (line_len >= LC_W'(MIN_LINE - 1)) begin
        r = central_slope(prev2_pos, prev2_val, prev2_ok, pos, val, ok);
        if (line_len == LC_W'(MIN_LINE - 1)) slopes_due.push_back(r);
        slopes_due.push_back(r);
      end
      prev2_pos = prev1_pos;
      prev2_val = prev1_val;
      prev2_ok  = prev1_ok;
      prev1_pos = pos;
      prev1_val = val;
      prev1_ok  = ok;
      if (line_len < LC_W'(MIN_LINE)) line_len = line_len + 1'b1;
    end
  endtask

  task automatic match_slope();
    slope_word_t want;
    if (slopes_due.size() == 0) begin
      $error("unexpected result word: slope %h, flags %b, line_last %b",
             out_tdata[DW-1:0], out_tuser, out_tlast);
      fail_total++;
      return;
    end
    want = slopes_due.pop_front();
    if (out_tdata[DW-1:0] !== want.slope) begin
      $error("slope: expected %h, got %h", want.slope, out_tdata[DW-1:0]);
      fail_total++;
    end
    if (out_tuser[0] !== want.slope_valid) begin
      $error("slope_valid: expected %b, got %b", want.slope_valid, out_tuser[0]);
      fail_total++;
    end
    if (out_tuser[1] !== want.saturated) begin
      $error("saturated: expected %b, got %b", want.saturated, out_tuser[1]);
      fail_total++;
    end
    if (out_tuser[2] !== want.short_line) begin
      $error("short_line: expected %b, got %b", want.short_line, out_tuser[2]);
      fail_total++;
    end
    if (out_tlast !== want.line_last) begin
      $error("line_last: expected %b, got %b", want.line_last, out_tlast);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      prev2_pos = '0;
      prev2_val = '0;
      prev2_ok  = 1'b0;
      prev1_pos = '0;
      prev1_val = '0;
      prev1_ok  = 1'b0;
      line_len  = '0;
      slopes_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        predict_slopes(in_tdata[DW-1:0], in_tdata[2*DW-1:DW], in_tuser[0], in_tlast);
      if (out_tvalid && out_tready) match_slope();
    end
    owed_now <= slopes_due.size();
  end

endmodule

// ----- bench/grid_line_central_difference_test.sv -----
`timescale 1ns / 1ps
// top of the grid_line_central_difference bench: clock, reset, sample stimulus,
// result backpressure, watchdog and verdict
// depends on gld_pkg, grid_line_central_difference and slope_stream_checker
module grid_line_central_difference_test;
  import gld_pkg::*;

  localparam int RANDOM_WORDS = 1050;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] position, [63:32] sample
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // [0] sample_valid
  logic                   in_tlast = 1'b0; // line_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] slope
  logic [OUT_TUSER_W-1:0] out_tuser;       // [0] slope_valid, [1] saturated, [2] short_line
  logic                   out_tlast;       // line_last

  int          words_owed;
  int          mismatches;
  int          words_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  logic [7:0]  ready_phase = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_line_central_difference u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  slope_stream_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .words_owed (words_owed),
    .mismatches (mismatches)
  );

  // sender works in bursts; a gap only opens before a word that starts a new burst
  task automatic send_word(input logic [DW-1:0] pos, input logic [DW-1:0] val,
                           input logic ok, input logic eol);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, pos};
    in_tuser  <= ok;
    in_tlast  <= eol;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  function automatic logic [DW-1:0] pick_value(input logic [DW-1:0] prior);
    logic [DW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = '0;
        endcase
      end
      default: v = prior + DW'($urandom_range(0, 1 << 20)) - DW'(1 << 19);
    endcase
    return v;
  endfunction

  task automatic send_random_line(output int len);
    int            style;
    logic [DW-1:0] pos, val, pos_back1, pos_back2, stride;
    logic          ok;
    case ($urandom_range(0, 15))
      0:       len = 1;
      1:       len = 2;
      2, 3:    len = 3;
      4:       len = $urandom_range(20, 60);
      default: len = $urandom_range(4, 12);
    endcase
    style = $urandom_range(0, 3);
    pos = $urandom;
    val = $urandom;
    pos_back1 = pos;
    pos_back2 = pos;
    for (int i = 0; i < len; i++) begin
      stride = DW'($urandom_range(1, 1 << 18));
      if (i >= 2 && $urandom_range(0, 15) == 0) pos = pos_back2;  // position tie
      else if (style == 0) pos = $urandom;
      else if (style == 1) pos = pos - stride;
      else pos = pos + stride;
      val = pick_value(val);
      ok = ($urandom_range(0, 11) != 0);
      send_word(pos, val, ok, i == len - 1);
      pos_back2 = pos_back1;
      pos_back1 = pos;
    end
  endtask

  initial begin
    int line_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one- and two-sample lines
    send_word(32'h0001_0000, 32'h1234_5678, 1'b1, 1'b1);
    send_word(32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0);
    send_word(32'h0001_0000, 32'h0000_0002, 1'b1, 1'b1);
    // three-sample line, slope 2.0, last word held over
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    send_word(32'h0001_0000, 32'h0002_0000, 1'b1, 1'b0);
    send_word(32'h0002_0000, 32'h0004_0000, 1'b1, 1'b1);
    // positive clamp, invalid neighbor, position tie
    send_word(32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    send_word(32'h0000_0001, 32'h7fff_ffff, 1'b1, 1'b0);
    send_word(32'h0000_0001, 32'h7fff_ffff, 1'b0, 1'b0);
    send_word(32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1);
    // negative clamp and extreme positions
    send_word(32'h0000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
    send_word(32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b0);
    send_word(32'h0000_0002, 32'h8000_0000, 1'b1, 1'b0);
    send_word(32'h8000_0000, 32'hffff_ffff, 1'b1, 1'b1);
    // exactly -32768.0, not clamped
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    send_word(32'h0000_8000, 32'h0000_0005, 1'b1, 1'b0);
    send_word(32'h0001_0000, 32'h8000_0000, 1'b1, 1'b1);
    // +32768.0 just over the top, then an invalid last sample
    send_word(32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0);
    send_word(32'hffff_0000, 32'h0000_1111, 1'b0, 1'b0);
    send_word(32'h0001_0000, 32'h0000_0000, 1'b1, 1'b0);
    send_word(32'h0002_0000, 32'h0001_0000, 1'b0, 1'b1);

    line_len = 0;
    while (words_sent < RANDOM_WORDS) send_random_line(line_len);
    // close on a long line so no word is left held over
    send_word(32'h0010_0000, 32'h0000_0100, 1'b1, 1'b0);
    send_word(32'h0011_0000, 32'hffff_0000, 1'b1, 1'b0);
    send_word(32'h0012_0000, 32'h0003_0000, 1'b1, 1'b0);
    send_word(32'h0013_0000, 32'h0000_0000, 1'b1, 1'b1);
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("grid_line_central_difference_test passed");
    else $display("grid_line_central_difference_test failed");
    $finish;
  end

  // receiver stalls follow a mode that changes when its random countdown runs out
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      ready_mode  <= READY_ALWAYS;
      mode_left   <= 0;
      ready_phase <= '0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      ready_phase <= ready_phase + 1'b1;
      case (ready_mode)
        READY_ALWAYS:   out_tready <= 1'b1;
        READY_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
        READY_PERIODIC: out_tready <= (ready_phase[3:0] < 4'd5);
        READY_SPARSE:   out_tready <= (ready_phase[4:0] == 5'd0);
        default:        out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("grid_line_central_difference_test failed");
        $finish;
      end
    end
  end

endmodule
